@@ src/sbd_pkg.sv @@
package sbd_pkg;

	// Field widths of the channels
	localparam int ACTION_W   = 2;
	localparam int CHAR_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int END_OFF_W  = 16;

	typedef logic [ACTION_W-1:0]  action_t;
	typedef logic [CHAR_W-1:0]    char_t;
	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [END_OFF_W-1:0] end_off_t;

	// Action codes
	localparam action_t ACT_CHAR    = 2'd0;
	localparam action_t ACT_END     = 2'd1;
	localparam action_t ACT_RESTART = 2'd2;

	// Status codes
	localparam status_t ST_PENDING    = 3'd0;
	localparam status_t ST_COMPLETE   = 3'd1;
	localparam status_t ST_MISMATCH   = 3'd2;
	localparam status_t ST_INCOMPLETE = 3'd3;
	localparam status_t ST_OVERFLOW   = 3'd4;

	// Characters of interest
	localparam char_t CH_LPAREN    = 8'h28;
	localparam char_t CH_RPAREN    = 8'h29;
	localparam char_t CH_LBRACK    = 8'h5B;
	localparam char_t CH_RBRACK    = 8'h5D;
	localparam char_t CH_HASH      = 8'h23;
	localparam char_t CH_BAR       = 8'h7C;
	localparam char_t CH_SEMI      = 8'h3B;
	localparam char_t CH_NEWLINE   = 8'h0A;
	localparam char_t CH_QUOTE     = 8'h22;
	localparam char_t CH_BACKSLASH = 8'h5C;
	localparam char_t CH_SPACE     = 8'h20;
	localparam char_t CH_TAB       = 8'h09;
	localparam char_t CH_CR        = 8'h0D;

	function automatic logic is_blank(char_t c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NEWLINE);
	endfunction

	function automatic logic is_delim(char_t c);
		return is_blank(c) || (c == CH_SEMI) || (c == CH_QUOTE) || (c == CH_LPAREN) ||
			(c == CH_LBRACK) || (c == CH_RPAREN) || (c == CH_RBRACK);
	endfunction

endpackage

@@ src/sbd_in_if.sv @@
interface sbd_in_if;
	import sbd_pkg::*;

	logic    valid;
	logic    ready;
	action_t action;
	char_t   character;

	modport source (output valid, output action, output character, input ready);
	modport sink (input valid, input action, input character, output ready);

endinterface

@@ src/sbd_out_if.sv @@
interface sbd_out_if;
	import sbd_pkg::*;

	logic     valid;
	logic     ready;
	status_t  status;
	end_off_t end_offset;

	modport source (output valid, output status, output end_offset, input ready);
	modport sink (input valid, input status, input end_offset, output ready);

endinterface

@@ src/sexpr_boundary_detector_core.sv @@
// Channel  | Dir | Payload                        | Transaction
// ---------+-----+--------------------------------+-----------------------------
// items    | in  | action[1:0], character[7:0]    | one byte, end mark or restart
// results  | out | status[2:0], end_offset[15:0]  | one verdict per item
//
// One item per cycle, sustained while results are taken; each result is registered.
// The closer stack lives in a synchronous RAM whose top entry is re-read every
// cycle from the next stack count, with write-to-read forwarding on a push.
// A two-entry output buffer lets an item enter while a result waits; items
// stall only when both entries are full. Reset clears all control state; the
// stack RAM needs no clearing pass, as only entries below the count are read.
module sexpr_boundary_detector_core #(
	parameter int MAX_NEST         = 64,
	parameter int MAX_COMMENT_NEST = 16,
	parameter int OFFSET_BITS      = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	sbd_in_if.sink    items,
	sbd_out_if.source results
);
	import sbd_pkg::*;

	localparam int CW = $clog2(MAX_NEST + 1);
	localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
	localparam int DW = $clog2(MAX_COMMENT_NEST + 1);

	// Scan mode codes
	localparam logic [2:0] M_START  = 3'd0;
	localparam logic [2:0] M_LINE   = 3'd1;
	localparam logic [2:0] M_TERM   = 3'd2;
	localparam logic [2:0] M_STRING = 3'd3;
	localparam logic [2:0] M_BLOCK  = 3'd4;
	localparam logic [2:0] M_HASH   = 3'd5;
	localparam logic [2:0] M_LIST   = 3'd6;

	// Lookahead codes in a block comment
	localparam logic [1:0] LA_NONE = 2'd0;
	localparam logic [1:0] LA_HASH = 2'd1;
	localparam logic [1:0] LA_BAR  = 2'd2;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

	// Scanner state
	logic [2:0]             mode_q, n_mode;
	logic                   in_list_q, n_in_list;
	logic                   esc_q, n_esc;
	logic [1:0]             la_q, n_la;
	logic [DW-1:0]          cdepth_q, n_cdepth;
	logic [OFFSET_BITS-1:0] pos_q, n_pos, pos_inc;
	status_t                verdict_q, n_verdict;
	logic [OFFSET_BITS-1:0] voff_q, n_voff;
	logic [CW-1:0]          count_q, n_count;

	// Stack RAM and its registered top
	logic           stack_mem [MAX_NEST];
	logic           top_q;
	logic           we;
	logic [AW-1:0]  wa, ra;
	logic           wd;
	logic [CW-1:0]  nc_dec;

	// Output buffer
	logic     out_valid_q, skid_valid_q;
	status_t  out_status_q, skid_status_q;
	end_off_t out_off_q, skid_off_q;
	logic     acc, take;
	logic [31:0] voff_ext;
	end_off_t new_off;

	logic do_list;
	logic c_open, c_close;
	char_t c;

	assign acc  = items.valid && items.ready;
	assign take = results.valid && results.ready;
	assign c    = items.character;
	assign pos_inc = (pos_q == OFF_MAX) ? pos_q : pos_q + 1'b1;
	assign c_open  = (c == CH_LPAREN) || (c == CH_LBRACK);
	assign c_close = (c == CH_RPAREN) || (c == CH_RBRACK);

	// Compute the next scanner state for the accepted item
	always_comb begin
		n_mode    = mode_q;
		n_in_list = in_list_q;
		n_esc     = esc_q;
		n_la      = la_q;
		n_cdepth  = cdepth_q;
		n_pos     = pos_q;
		n_verdict = verdict_q;
		n_voff    = voff_q;
		n_count   = count_q;
		we        = 1'b0;
		wa        = count_q[AW-1:0];
		wd        = (c == CH_LBRACK);
		do_list   = 1'b0;

		if (acc) begin
			if (items.action == ACT_RESTART) begin
				n_mode    = M_START;
				n_in_list = 1'b0;
				n_esc     = 1'b0;
				n_la      = LA_NONE;
				n_cdepth  = '0;
				n_pos     = '0;
				n_verdict = ST_PENDING;
				n_voff    = '0;
				n_count   = '0;
			end else if (items.action == ACT_CHAR && verdict_q == ST_PENDING) begin
				n_pos = pos_inc;
				case (mode_q)
					M_START: begin
						if (is_blank(c)) begin
						end else if (c == CH_SEMI) begin
							n_mode = M_LINE;
						end else if (c_open) begin
							n_in_list = 1'b1;
							n_mode    = M_LIST;
							if (count_q >= CW'(MAX_NEST)) begin
								n_verdict = ST_OVERFLOW;
								n_voff    = '0;
							end else begin
								we      = 1'b1;
								n_count = count_q + 1'b1;
							end
						end else if (c == CH_QUOTE) begin
							n_mode = M_STRING;
							n_esc  = 1'b0;
						end else if (c == CH_HASH) begin
							n_mode = M_HASH;
						end else if (is_delim(c)) begin
							// lone closer: empty term ending here
							n_verdict = ST_COMPLETE;
							n_voff    = pos_q;
						end else begin
							n_mode = M_TERM;
						end
					end
					M_LINE: begin
						if (c == CH_NEWLINE)
							n_mode = in_list_q ? M_LIST : M_START;
					end
					M_STRING: begin
						if (esc_q) begin
							n_esc = 1'b0;
						end else if (c == CH_BACKSLASH) begin
							n_esc = 1'b1;
						end else if (c == CH_QUOTE) begin
							if (in_list_q) begin
								n_mode = M_LIST;
							end else begin
								n_verdict = ST_COMPLETE;
								n_voff    = pos_inc;
							end
						end
					end
					M_BLOCK: begin
						if (la_q == LA_HASH && c == CH_BAR) begin
							n_la = LA_NONE;
							if (cdepth_q >= DW'(MAX_COMMENT_NEST)) begin
								n_verdict = ST_OVERFLOW;
								n_voff    = '0;
							end else begin
								n_cdepth = cdepth_q + 1'b1;
							end
						end else if (la_q == LA_BAR && c == CH_HASH) begin
							n_la = LA_NONE;
							if (cdepth_q != '0)
								n_cdepth = cdepth_q - 1'b1;
							if (cdepth_q <= DW'(1)) begin
								if (in_list_q) begin
									n_mode = M_LIST;
								end else begin
									n_verdict = ST_COMPLETE;
									n_voff    = pos_inc;
								end
							end
						end else begin
							n_la = (c == CH_HASH) ? LA_HASH : (c == CH_BAR) ? LA_BAR : LA_NONE;
						end
					end
					M_TERM, M_HASH: begin
						if (mode_q == M_HASH && c == CH_BAR) begin
							n_mode   = M_BLOCK;
							n_cdepth = DW'(1);
							n_la     = LA_NONE;
						end else if (!is_delim(c)) begin
							n_mode = M_TERM;
						end else if (in_list_q) begin
							n_mode  = M_LIST;
							do_list = 1'b1;
						end else begin
							n_verdict = ST_COMPLETE;
							n_voff    = pos_q;
						end
					end
					default: begin
						do_list = 1'b1;
					end
				endcase

				// Handle a byte at list level
				if (do_list) begin
					if (is_blank(c)) begin
					end else if (c == CH_SEMI) begin
						n_mode = M_LINE;
					end else if (c_close) begin
						if (count_q == '0 || top_q != (c == CH_RBRACK)) begin
							n_verdict = ST_MISMATCH;
							n_voff    = '0;
						end else begin
							n_count = count_q - 1'b1;
							if (count_q == CW'(1)) begin
								n_verdict = ST_COMPLETE;
								n_voff    = pos_inc;
							end
						end
					end else if (c == CH_QUOTE) begin
						n_mode = M_STRING;
						n_esc  = 1'b0;
					end else if (c == CH_HASH) begin
						n_mode = M_HASH;
					end else if (c_open) begin
						if (count_q >= CW'(MAX_NEST)) begin
							n_verdict = ST_OVERFLOW;
							n_voff    = '0;
						end else begin
							we      = 1'b1;
							n_count = count_q + 1'b1;
						end
					end else begin
						n_mode = M_TERM;
					end
				end
			end else if (items.action == ACT_END && verdict_q == ST_PENDING) begin
				if (!in_list_q && (mode_q == M_TERM || mode_q == M_HASH)) begin
					n_verdict = ST_COMPLETE;
					n_voff    = pos_q;
				end else begin
					n_verdict = ST_INCOMPLETE;
					n_voff    = '0;
				end
			end
		end
	end

	// Read address: top entry under the next count
	assign nc_dec = (n_count == '0) ? '0 : n_count - 1'b1;
	assign ra     = nc_dec[AW-1:0];

	// Write the stack RAM
	always_ff @(posedge clk) begin
		if (we)
			stack_mem[wa] <= wd;
	end

	// Read the top entry, forwarding a same-cycle push
	always_ff @(posedge clk) begin
		if (we && wa == ra)
			top_q <= wd;
		else
			top_q <= stack_mem[ra];
	end

	// Advance scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_START;
			in_list_q <= 1'b0;
			esc_q     <= 1'b0;
			la_q      <= LA_NONE;
			cdepth_q  <= '0;
			pos_q     <= '0;
			verdict_q <= ST_PENDING;
			voff_q    <= '0;
			count_q   <= '0;
		end else begin
			mode_q    <= n_mode;
			in_list_q <= n_in_list;
			esc_q     <= n_esc;
			la_q      <= n_la;
			cdepth_q  <= n_cdepth;
			pos_q     <= n_pos;
			verdict_q <= n_verdict;
			voff_q    <= n_voff;
			count_q   <= n_count;
		end
	end

	// Cut the offset to the port width
	assign voff_ext = 32'(n_voff);
	assign new_off  = (n_verdict == ST_COMPLETE) ? voff_ext[END_OFF_W-1:0] : '0;

	// Output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take && skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (acc) begin
				if (out_valid_q && !take)
					skid_valid_q <= 1'b1;
				else
					out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output buffer payload
	always_ff @(posedge clk) begin
		if (take && skid_valid_q) begin
			out_status_q <= skid_status_q;
			out_off_q    <= skid_off_q;
		end else if (acc) begin
			if (out_valid_q && !take) begin
				skid_status_q <= n_verdict;
				skid_off_q    <= new_off;
			end else begin
				out_status_q <= n_verdict;
				out_off_q    <= new_off;
			end
		end
	end

	assign items.ready        = !skid_valid_q;
	assign results.valid      = out_valid_q;
	assign results.status     = out_status_q;
	assign results.end_offset = out_off_q;

`ifndef SYNTHESIS
	// A final verdict holds until a restart
	a_verdict_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(verdict_q != ST_PENDING && !(acc && items.action == ACT_RESTART))
		|=> $stable(verdict_q))
		else $error("final verdict changed without restart");

	// The skid entry is only used behind a full main entry
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with main entry empty");

	// Stack count never exceeds the nesting limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_NEST))
		else $error("stack count beyond limit");

	// Only a complete verdict carries an offset
	a_offset_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.status != ST_COMPLETE) |-> (results.end_offset == '0))
		else $error("offset on a non-complete verdict");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import sbd_pkg::*;

	localparam int NEST_LIMIT    = 64;
	localparam int COMMENT_LIMIT = 16;
	localparam int OFF_BITS      = 16;
	localparam int unsigned OFF_SAT = (32'd1 << OFF_BITS) - 1;

	// Unused action code: the block repeats its verdict
	localparam action_t ACT_SPARE = 2'd3;
	localparam char_t   CH_A      = 8'h61;

	localparam int RANDOM_ITEMS = 1600;
	localparam int MAX_WAIT     = 12;
	localparam int STALL_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 8;
	localparam int REPORT_MAX   = 10;

	typedef enum logic [2:0] {
		SM_START, SM_LINE, SM_TERM, SM_STRING, SM_BLOCK, SM_HASH, SM_LIST
	} scan_e;

	typedef enum logic [1:0] {PK_NONE, PK_HASH, PK_BAR} peek_e;

	typedef struct packed {
		status_t  st;
		end_off_t off;
	} verdict_t;

	typedef struct packed {
		action_t  act;
		char_t    ch;
		logic     typed;
		status_t  st;
		end_off_t off;
	} drill_row_t;

	// Directed rows; a typed verdict is checked as given, the rest by the scanner model
	localparam int DRILL_ROWS = 30;
	localparam drill_row_t DRILL [DRILL_ROWS] = '{
		'{ACT_END,     8'h00,        1'b1, ST_INCOMPLETE, 16'd0},
		'{ACT_CHAR,    8'h00,        1'b1, ST_INCOMPLETE, 16'd0},
		'{ACT_SPARE,   8'hFF,        1'b1, ST_INCOMPLETE, 16'd0},
		'{ACT_RESTART, 8'hFF,        1'b1, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_RPAREN,    1'b1, ST_COMPLETE,   16'd0},
		'{ACT_RESTART, 8'h00,        1'b1, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_SEMI,      1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    8'hFF,        1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_NEWLINE,   1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_LBRACK,    1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_HASH,      1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_QUOTE,     1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_BACKSLASH, 1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_QUOTE,     1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_QUOTE,     1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_HASH,      1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_BAR,       1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_BAR,       1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_HASH,      1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_RPAREN,    1'b1, ST_MISMATCH,   16'd0},
		'{ACT_RESTART, 8'h00,        1'b1, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_HASH,      1'b0, ST_PENDING,    16'd0},
		'{ACT_END,     8'h00,        1'b0, ST_PENDING,    16'd0},
		'{ACT_RESTART, 8'h00,        1'b1, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_A,         1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_LPAREN,    1'b0, ST_PENDING,    16'd0},
		'{ACT_RESTART, 8'h00,        1'b1, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_CR,        1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_LBRACK,    1'b0, ST_PENDING,    16'd0},
		'{ACT_CHAR,    CH_RBRACK,    1'b0, ST_PENDING,    16'd0}
	};

	logic clk;
	logic arst_n;

	sbd_in_if  items ();
	sbd_out_if results ();

	sexpr_boundary_detector_core #(
		.MAX_NEST        (NEST_LIMIT),
		.MAX_COMMENT_NEST(COMMENT_LIMIT),
		.OFFSET_BITS     (OFF_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.results(results)
	);

	// Expectation carried alongside the payload of a directed row
	logic     row_typed;
	status_t  row_st;
	end_off_t row_off;

	verdict_t due_verdicts[$];
	char_t    text_q[$];

	int  items_in;
	int  verdicts_out;
	int  live_items;
	int  miss_cnt;
	int  rx_hold;
	int  idle_cycles;
	bit  quiet_tx;
	bit  quiet_rx;

	// Scanner model state
	bit          closer_brack [NEST_LIMIT];
	int unsigned open_cnt;
	int unsigned cmt_depth;
	int unsigned scan_pos;
	int unsigned verdict_off;
	scan_e       scan;
	peek_e       peek;
	bit          in_list;
	bit          esc_next;
	status_t     verdict;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- scanner model

	function automatic bit ws_byte(char_t c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NEWLINE;
	endfunction

	function automatic bit term_stop(char_t c);
		return ws_byte(c) || c == CH_SEMI || c == CH_QUOTE || c == CH_LPAREN ||
			c == CH_LBRACK || c == CH_RPAREN || c == CH_RBRACK;
	endfunction

	function automatic int unsigned step_pos(int unsigned v);
		return (v >= OFF_SAT) ? OFF_SAT : v + 1;
	endfunction

	function automatic void settle(status_t st, int unsigned off);
		verdict = st;
		verdict_off = (st == ST_COMPLETE) ? off : 0;
	endfunction

	function automatic void datum_done(int unsigned off);
		if (in_list)
			scan = SM_LIST;
		else
			settle(ST_COMPLETE, off);
	endfunction

	function automatic void push_level(char_t c);
		if (open_cnt >= NEST_LIMIT) begin
			settle(ST_OVERFLOW, 0);
			return;
		end
		closer_brack[open_cnt] = (c == CH_LBRACK);
		open_cnt++;
	endfunction

	function automatic void list_byte(char_t c);
		if (ws_byte(c))
			return;
		if (c == CH_SEMI) begin
			scan = SM_LINE;
		end else if (c == CH_RPAREN || c == CH_RBRACK) begin
			if (open_cnt == 0 || closer_brack[open_cnt-1] != (c == CH_RBRACK)) begin
				settle(ST_MISMATCH, 0);
				return;
			end
			open_cnt--;
			if (open_cnt == 0)
				settle(ST_COMPLETE, step_pos(scan_pos));
		end else if (c == CH_QUOTE) begin
			scan = SM_STRING;
			esc_next = 1'b0;
		end else if (c == CH_HASH) begin
			scan = SM_HASH;
		end else if (c == CH_LPAREN || c == CH_LBRACK) begin
			push_level(c);
		end else begin
			scan = SM_TERM;
		end
	endfunction

	function automatic void term_byte(char_t c);
		if (!term_stop(c)) begin
			scan = SM_TERM;
			return;
		end
		if (in_list) begin
			scan = SM_LIST;
			list_byte(c);
		end else begin
			settle(ST_COMPLETE, scan_pos);
		end
	endfunction

	// Block comment: pair up "#|" and "|#" greedily
	function automatic void block_byte(char_t c);
		if (peek == PK_HASH && c == CH_BAR) begin
			peek = PK_NONE;
			if (cmt_depth >= COMMENT_LIMIT) begin
				settle(ST_OVERFLOW, 0);
				return;
			end
			cmt_depth++;
			return;
		end
		if (peek == PK_BAR && c == CH_HASH) begin
			peek = PK_NONE;
			if (cmt_depth > 0)
				cmt_depth--;
			if (cmt_depth == 0)
				datum_done(step_pos(scan_pos));
			return;
		end
		if (c == CH_HASH)
			peek = PK_HASH;
		else if (c == CH_BAR)
			peek = PK_BAR;
		else
			peek = PK_NONE;
	endfunction

	function automatic void scan_byte(char_t c);
		case (scan)
			SM_START: begin
				if (ws_byte(c)) begin
				end else if (c == CH_SEMI) begin
					scan = SM_LINE;
				end else if (c == CH_LPAREN || c == CH_LBRACK) begin
					in_list = 1'b1;
					scan = SM_LIST;
					push_level(c);
				end else if (c == CH_QUOTE) begin
					scan = SM_STRING;
					esc_next = 1'b0;
				end else if (c == CH_HASH) begin
					scan = SM_HASH;
				end else begin
					term_byte(c);
				end
			end
			SM_LINE: begin
				if (c == CH_NEWLINE) begin
					if (in_list)
						scan = SM_LIST;
					else
						scan = SM_START;
				end
			end
			SM_TERM: term_byte(c);
			SM_STRING: begin
				if (esc_next)
					esc_next = 1'b0;
				else if (c == CH_BACKSLASH)
					esc_next = 1'b1;
				else if (c == CH_QUOTE)
					datum_done(step_pos(scan_pos));
			end
			SM_BLOCK: block_byte(c);
			SM_HASH: begin
				if (c == CH_BAR) begin
					scan = SM_BLOCK;
					cmt_depth = 1;
					peek = PK_NONE;
				end else begin
					term_byte(c);
				end
			end
			default: list_byte(c);
		endcase
	endfunction

	function automatic void clear_scan();
		foreach (closer_brack[i])
			closer_brack[i] = 1'b0;
		open_cnt = 0;
		cmt_depth = 0;
		scan_pos = 0;
		verdict_off = 0;
		scan = SM_START;
		peek = PK_NONE;
		in_list = 1'b0;
		esc_next = 1'b0;
		verdict = ST_PENDING;
	endfunction

	// Advance the scanner by one transaction and return the verdict it reports
	function automatic void scan_advance(action_t a, char_t c, output status_t st,
			output end_off_t off);
		case (a)
			ACT_RESTART: clear_scan();
			ACT_CHAR: begin
				if (verdict == ST_PENDING) begin
					scan_byte(c);
					scan_pos = step_pos(scan_pos);
				end
			end
			ACT_END: begin
				if (verdict == ST_PENDING) begin
					if (!in_list && (scan == SM_TERM || scan == SM_HASH))
						settle(ST_COMPLETE, scan_pos);
					else
						settle(ST_INCOMPLETE, 0);
				end
			end
			default: ;
		endcase
		st = verdict;
		off = (verdict == ST_COMPLETE) ? end_off_t'(verdict_off) : '0;
	endfunction

	// ---------------------------------------------------------------- text generation

	function automatic char_t any_byte();
		return char_t'($urandom_range(0, 255));
	endfunction

	function automatic char_t word_byte();
		char_t c;
		do
			c = any_byte();
		while (term_stop(c) || c == CH_HASH || c == CH_BAR);
		return c;
	endfunction

	function automatic void add_gap();
		int n;
		n = $urandom_range(0, 2);
		repeat (n) begin
			case ($urandom_range(0, 4))
				0: text_q.push_back(CH_SPACE);
				1: text_q.push_back(CH_TAB);
				2: text_q.push_back(CH_CR);
				3: text_q.push_back(CH_NEWLINE);
				default: begin
					text_q.push_back(CH_SEMI);
					repeat ($urandom_range(0, 5)) begin
						char_t c;
						c = any_byte();
						text_q.push_back((c == CH_NEWLINE) ? CH_A : c);
					end
					text_q.push_back(CH_NEWLINE);
				end
			endcase
		end
	endfunction

	function automatic void add_word();
		text_q.push_back(word_byte());
		repeat ($urandom_range(0, 4))
			text_q.push_back(word_byte());
	endfunction

	function automatic void add_text();
		char_t c;
		text_q.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			if ($urandom_range(0, 5) == 0) begin
				text_q.push_back(CH_BACKSLASH);
				text_q.push_back(any_byte());
			end else begin
				do
					c = any_byte();
				while (c == CH_QUOTE || c == CH_BACKSLASH);
				text_q.push_back(c);
			end
		end
		text_q.push_back(CH_QUOTE);
	endfunction

	function automatic void add_note(int d);
		char_t c;
		text_q.push_back(CH_HASH);
		text_q.push_back(CH_BAR);
		repeat ($urandom_range(0, 3)) begin
			if (d < 3 && $urandom_range(0, 2) == 0) begin
				add_note(d + 1);
			end else begin
				do
					c = any_byte();
				while (c == CH_HASH || c == CH_BAR);
				text_q.push_back(c);
			end
		end
		text_q.push_back(CH_BAR);
		text_q.push_back(CH_HASH);
	endfunction

	function automatic void add_list(int d);
		bit sq;
		sq = 1'($urandom_range(0, 1));
		text_q.push_back(sq ? CH_LBRACK : CH_LPAREN);
		repeat ($urandom_range(0, 4)) begin
			add_gap();
			add_datum(d + 1);
			text_q.push_back(CH_SPACE);
		end
		add_gap();
		text_q.push_back(sq ? CH_RBRACK : CH_RPAREN);
	endfunction

	function automatic void add_datum(int d);
		case ($urandom_range(0, (d < 5) ? 6 : 4))
			0, 1: add_word();
			2: begin
				text_q.push_back(CH_HASH);
				if ($urandom_range(0, 1))
					add_word();
			end
			3: add_text();
			4: add_note(0);
			default: add_list(d);
		endcase
	endfunction

	// ---------------------------------------------------------------- driving

	task automatic put_item(action_t a, char_t c, bit typed = 1'b0,
			status_t st = ST_PENDING, end_off_t off = '0);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid <= 1'b1;
		items.action <= a;
		items.character <= c;
		row_typed <= typed;
		row_st <= st;
		row_off <= off;
		do
			@(posedge clk);
		while (!items.ready);
		items_in++;
	endtask

	// Hold the sender until every verdict in flight has come back
	task automatic drain();
		items.valid <= 1'b0;
		do
			@(posedge clk);
		while (verdicts_out < items_in);
	endtask

	task automatic run_sequence(int idx);
		int  kind;
		int  deep;
		int  cut;
		bit  kinds[$];
		text_q.delete();
		quiet_tx = ($urandom_range(0, 4) == 0);
		quiet_rx = ($urandom_range(0, 4) == 0);
		kind = (idx == 0) ? 18 : (idx == 1) ? 19 : $urandom_range(0, 19);
		case (kind)
			// deep list: one level past the limit overflows, exactly the limit closes
			18: begin
				deep = NEST_LIMIT + ((idx == 0) ? 1 : $urandom_range(0, 1));
				repeat (deep) begin
					kinds.push_back(1'($urandom_range(0, 1)));
					text_q.push_back(kinds[kinds.size()-1] ? CH_LBRACK : CH_LPAREN);
				end
				if (deep == NEST_LIMIT)
					while (kinds.size() != 0)
						text_q.push_back(kinds.pop_back() ? CH_RBRACK : CH_RPAREN);
			end
			// deep block comment
			19: begin
				deep = COMMENT_LIMIT + ((idx == 1) ? 1 : $urandom_range(0, 1));
				repeat (deep) begin
					text_q.push_back(CH_HASH);
					text_q.push_back(CH_BAR);
				end
				if (deep == COMMENT_LIMIT)
					repeat (deep) begin
						text_q.push_back(CH_BAR);
						text_q.push_back(CH_HASH);
					end
			end
			16: begin
				repeat ($urandom_range(1, 10))
					text_q.push_back(any_byte());
			end
			// list with the wrong closer at the end
			17: begin
				add_list(0);
				if (text_q[text_q.size()-1] == CH_RPAREN)
					text_q[text_q.size()-1] = CH_RBRACK;
				else
					text_q[text_q.size()-1] = CH_RPAREN;
			end
			default: begin
				add_gap();
				add_datum(0);
				if (kind == 12 || kind == 13) begin
					cut = $urandom_range(1, text_q.size());
					repeat (cut) void'(text_q.pop_back());
				end else if (kind == 14 || kind == 15) begin
					text_q[$urandom_range(0, text_q.size()-1)] = any_byte();
				end
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 3)) text_q.push_back(any_byte());
			end
		endcase
		if (idx == 2 || $urandom_range(0, 14) == 0)
			drain();
		put_item(ACT_RESTART, any_byte());
		foreach (text_q[i]) begin
			if ($urandom_range(0, 39) == 0)
				put_item(ACT_SPARE, any_byte());
			put_item(ACT_CHAR, text_q[i]);
		end
		if ($urandom_range(0, 3) != 0)
			put_item(ACT_END, any_byte());
	endtask

	// ---------------------------------------------------------------- result side

	// Draw a fresh stall after each transaction, then count it down
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_hold = 0;
			results.ready <= 1'b0;
		end else if (results.valid && results.ready) begin
			rx_hold = quiet_rx ? 0 : $urandom_range(0, MAX_WAIT);
			results.ready <= (rx_hold == 0);
		end else if (!results.ready) begin
			if (rx_hold <= 1)
				results.ready <= 1'b1;
			if (rx_hold > 0)
				rx_hold--;
		end
	end

	// Check each verdict against the oldest one due, then predict for new input
	always @(posedge clk) begin : check_blk
		verdict_t want;
		verdict_t got;
		status_t  pst;
		end_off_t poff;
		if (arst_n) begin
			if (results.valid && results.ready) begin
				got.st = results.status;
				got.off = results.end_offset;
				verdicts_out++;
				if (due_verdicts.size() == 0) begin
					miss_cnt++;
					if (miss_cnt <= REPORT_MAX)
						$display("tb: unexpected verdict status %0d end_offset %0d",
							got.st, got.off);
				end else begin
					want = due_verdicts.pop_front();
					if (got.st !== want.st || got.off !== want.off) begin
						miss_cnt++;
						if (miss_cnt <= REPORT_MAX)
							$display("tb: verdict %0d: expected status %0d end_offset %0d, got status %0d end_offset %0d",
								verdicts_out, want.st, want.off, got.st, got.off);
					end
				end
			end
			if (items.valid && items.ready) begin
				if (items.action == ACT_RESTART ||
						(verdict == ST_PENDING && items.action != ACT_SPARE))
					live_items++;
				scan_advance(items.action, items.character, pst, poff);
				if (row_typed) begin
					want.st = row_st;
					want.off = row_off;
				end else begin
					want.st = pst;
					want.off = poff;
				end
				due_verdicts.push_back(want);
			end
		end
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (items.valid && items.ready) || (results.valid && results.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : stimulus
		int seq_n;
		items.valid <= 1'b0;
		items.action <= ACT_CHAR;
		items.character <= '0;
		row_typed <= 1'b0;
		row_st <= ST_PENDING;
		row_off <= '0;
		arst_n <= 1'b0;
		items_in = 0;
		verdicts_out = 0;
		live_items = 0;
		miss_cnt = 0;
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		seq_n = 0;
		clear_scan();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows
		foreach (DRILL[i])
			put_item(DRILL[i].act, DRILL[i].ch, DRILL[i].typed, DRILL[i].st, DRILL[i].off);

		// random sequences until enough live transactions have gone in
		while (live_items < DRILL_ROWS + RANDOM_ITEMS) begin
			run_sequence(seq_n);
			seq_n++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_verdicts.size() != 0) begin
			miss_cnt += due_verdicts.size();
			$display("tb: %0d verdicts never arrived", due_verdicts.size());
		end
		if (miss_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
